@@ hw/rtl/wg_pkg.sv @@
// ----------------------------------------------------------------------------
// wg_pkg
// Shared constants, types and the quarter-wave sine table builder for the
// waveform generator.
// ----------------------------------------------------------------------------
package wg_pkg;

  localparam int PHASE_BITS           = 32;
  localparam int SAMPLE_BITS          = 10;
  localparam int SINE_TABLE_ADDR_BITS = 8;

  localparam int SAMPLE_W    = SAMPLE_BITS + 1;
  localparam int MAG_W       = SAMPLE_BITS;
  localparam int TRI_W       = SAMPLE_BITS - 1;
  localparam int TBL_N       = 1 << SINE_TABLE_ADDR_BITS;
  localparam int ROM_AW      = SINE_TABLE_ADDR_BITS + 1;
  localparam int TRI_SHIFT   = PHASE_BITS - 2 - TRI_W;
  localparam int STEP_W      = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;

  localparam logic [MAG_W-1:0]  AMP          = MAG_W'(1) << TRI_W;
  localparam logic [STEP_W-1:0] STEP_RESET   = 32'd429496730;
  localparam logic [63:0]       HALF_PI_Q62  = 64'h6487ED5110B4611A;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_SQUARE   = 2'd2
  } wave_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WAVE_SELECT = 1'b0,
    REG_PHASE_STEP  = 1'b1
  } cfg_reg_e;

  typedef logic [MAG_W-1:0] mag_t;
  typedef mag_t sine_tbl_t [TBL_N+1];

  // payload of the stage that waits on the table read
  typedef struct packed {
    logic [1:0]       wave;
    logic [1:0]       quad;
    logic [TRI_W-1:0] tri_lo;
    logic             tri_rem_nz;
  } s1_t;

  // floor(a*b / 2^62)
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // sin(pi/2 * k / N) in unsigned Q2.62 by a taylor series
  function automatic logic [63:0] sine_q62(logic [63:0] k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] prod;
    x    = mul_q62(HALF_PI_Q62, k << (62 - SINE_TABLE_ADDR_BITS));
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n <= 13; n++) begin
      prod = mul_q62(term, x2);
      case (n)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        6:       term = prod / 64'd156;
        7:       term = prod / 64'd210;
        8:       term = prod / 64'd272;
        9:       term = prod / 64'd342;
        10:      term = prod / 64'd420;
        11:      term = prod / 64'd506;
        12:      term = prod / 64'd600;
        default: term = prod / 64'd702;
      endcase
      if ((n & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic sine_tbl_t build_sine_tbl();
    sine_tbl_t   t;
    logic [63:0] s;
    t[0] = '0;
    for (int k = 1; k < TBL_N; k++) begin
      s    = sine_q62(64'(k));
      t[k] = MAG_W'(s >> (62 - TRI_W));
    end
    t[TBL_N] = AMP;
    return t;
  endfunction

endpackage

@@ hw/rtl/waveform_generator.sv @@
// ----------------------------------------------------------------------------
// waveform_generator
// Phase-accumulator function generator: sine, triangle or square samples.
// ----------------------------------------------------------------------------
// Takes one tick item per clock, back to back, while the output does not stall. A
// tick with run set yields one signed sample through the table read register and
// then the output register, and advances the phase by phase_step; a tick with
// run clear holds the phase and yields nothing. The registered read of the
// quarter-wave sine table is the first stage; both stages stall together while the output item waits.
// wave_select 3 gives a sample of zero. Write configuration only while idle.
module waveform_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [wg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [0] run
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [wg_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [10:0] sample
  input  logic                             cfg_we_i,
  input  logic [wg_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [wg_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import wg_pkg::*;

  logic [1:0]                  wave_q;
  logic [STEP_W-1:0]           step_q;
  logic [PHASE_BITS-1:0]       phase_q;
  logic [PHASE_BITS-1:0]       phase_d;
  logic                        s1_valid_q;
  s1_t                         s1_q;
  s1_t                         s1_d;
  logic                        adv;
  logic                        accept;
  logic                        run;
  logic [1:0]                  quad;
  logic [SINE_TABLE_ADDR_BITS-1:0] tbl_i;
  logic [ROM_AW-1:0]           rom_addr;
  logic [PHASE_BITS-3:0]       frac;
  mag_t                        rom_data;
  logic [SAMPLE_W-1:0]         sample;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;
  assign run           = s_axis_tdata[0];

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= WAVE_SINE;
      step_q <= STEP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WAVE_SELECT: wave_q <= cfg_data_i[1:0];
        REG_PHASE_STEP:  step_q <= cfg_data_i[STEP_W-1:0];
        default:         ;
      endcase
    end
  end

  // table address and triangle terms from the current phase
  assign quad     = phase_q[PHASE_BITS-1 -: 2];
  assign tbl_i    = phase_q[PHASE_BITS-3 -: SINE_TABLE_ADDR_BITS];
  assign rom_addr = quad[0] ? (ROM_AW'(TBL_N) - {1'b0, tbl_i}) : {1'b0, tbl_i};
  assign frac     = phase_q[PHASE_BITS-3:0];

  always_comb begin
    s1_d.wave       = wave_q;
    s1_d.quad       = quad;
    s1_d.tri_lo     = TRI_W'(frac >> TRI_SHIFT);
    s1_d.tri_rem_nz = |frac[TRI_SHIFT-1:0];
  end

  assign phase_d = phase_q + PHASE_BITS'(step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept && run) begin
        phase_q <= phase_d;
      end
      if (adv) begin
        s1_valid_q <= accept && run;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
    end
  end

  wg_sine_rom u_rom (
    .clk_i     (clk_i),
    .rd_en_i   (adv),
    .rd_addr_i (rom_addr),
    .rd_data_o (rom_data)
  );

  wg_shaper u_shaper (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .s1_valid_i  (s1_valid_q),
    .s1_i        (s1_q),
    .mag_i       (rom_data),
    .out_valid_o (m_axis_tvalid),
    .sample_o    (sample)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-SAMPLE_W){1'b0}}, sample};

  localparam logic signed [SAMPLE_W-1:0] AmpPos = SAMPLE_W'(AMP);
  localparam logic signed [SAMPLE_W-1:0] AmpNeg = -SAMPLE_W'(AMP);

  // a paused tick never reaches the table stage
  a_pause_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !run) |=> !s1_valid_q)
    else $error("paused tick produced an item");

  // the table stage keeps its item while the output stalls
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> s1_valid_q)
    else $error("table stage item lost under stall");

  // no sample ever exceeds the amplitude
  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(sample) <= AmpPos && $signed(sample) >= AmpNeg))
    else $error("sample out of range");

  // phase only moves on an accepted running tick
  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && run) |=> $stable(phase_q))
    else $error("phase moved without a running tick");

endmodule

@@ hw/rtl/wg_sine_rom.sv @@
// ----------------------------------------------------------------------------
// wg_sine_rom
// Quarter-wave sine magnitude table, one registered read port.
// ----------------------------------------------------------------------------
module wg_sine_rom (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [wg_pkg::ROM_AW-1:0] rd_addr_i,
  output wg_pkg::mag_t              rd_data_o
);
  import wg_pkg::*;

  localparam sine_tbl_t SineRom = build_sine_tbl();

  mag_t rd_data_q;

  // read data holds while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= SineRom[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/wg_shaper.sv @@
// ----------------------------------------------------------------------------
// wg_shaper
// Forms the signed sample from table data or phase bits and holds it in the
// output register.
// ----------------------------------------------------------------------------
module wg_shaper (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        s1_valid_i,
  input  wg_pkg::s1_t                 s1_i,
  input  wg_pkg::mag_t                mag_i,
  output logic                        out_valid_o,
  output logic [wg_pkg::SAMPLE_W-1:0] sample_o
);
  import wg_pkg::*;

  logic                       out_valid_q;
  logic [SAMPLE_W-1:0]        sample_q;
  logic [SAMPLE_W-1:0]        sample_d;
  mag_t                       mag;
  mag_t                       tri_hi;
  mag_t                       tri_fall;
  logic [SAMPLE_W-1:0]        mag_ext;

  // falling quarter of the triangle rounds up before the subtract
  assign tri_hi   = {1'b0, s1_i.tri_lo} + MAG_W'(s1_i.tri_rem_nz);
  assign tri_fall = AMP - tri_hi;

  always_comb begin
    unique case (s1_i.wave)
      WAVE_SINE:     mag = mag_i;
      WAVE_TRIANGLE: mag = s1_i.quad[0] ? tri_fall : {1'b0, s1_i.tri_lo};
      WAVE_SQUARE:   mag = AMP;
      default:       mag = '0;
    endcase
    mag_ext  = {1'b0, mag};
    sample_d = s1_i.quad[1] ? (~mag_ext + SAMPLE_W'(1)) : mag_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sample_q <= sample_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

endmodule

@@ bench/tb_waveform_generator.sv @@
// ----------------------------------------------------------------------------
// tb_waveform_generator
// Self-checking bench for the phase-accumulator function generator. Tick
// items go in on the slave stream and their samples are predicted from a local
// phase accumulator and quarter-wave sine table. Each output item is checked
// in order against the queue of predicted samples. Both stream sides idle at
// random. The configuration is rewritten between phases once the block has
// drained.
// ----------------------------------------------------------------------------
module tb_waveform_generator;
  import wg_pkg::*;

  localparam int          STALL_LIMIT   = 1000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          AMP_INT       = 1 << (SAMPLE_BITS - 1);
  localparam int          FRAC_SHIFT    = 62 - SINE_TABLE_ADDR_BITS;
  localparam logic [63:0] HALF_PI_FIX   = 64'h6487ED5110B4611A;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [0] run
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [10:0] sample
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  waveform_generator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // local copy of the generator state
  logic [PHASE_BITS-1:0]      gen_phase;
  logic [STEP_W-1:0]          gen_step;
  logic [1:0]                 gen_wave;
  logic [MAG_W-1:0]           sine_quarter [TBL_N+1];
  logic signed [SAMPLE_W-1:0] expected_samples [$];
  int                         mismatch_count;
  int                         idle_cycles;
  bit                         no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] wide;
    wide = 128'(a) * 128'(b);
    return 64'(wide >> 62);
  endfunction

  // taylor series of sin(pi/2 * k / N), unsigned q2.62
  function automatic logic [MAG_W-1:0] sine_mag(int k);
    logic [63:0] x;
    logic [63:0] x_sq;
    logic [63:0] term;
    logic [63:0] acc;
    x    = fix_mul(HALF_PI_FIX, 64'(k) << FRAC_SHIFT);
    x_sq = fix_mul(x, x);
    term = x;
    acc  = x;
    for (int n = 1; n <= 13; n++) begin
      term = fix_mul(term, x_sq) / 64'(4 * n * n + 2 * n);
      acc  = (n % 2 == 1) ? acc - term : acc + term;
    end
    return MAG_W'(acc >> (62 - TRI_W));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] predict_sample(
      logic [PHASE_BITS-1:0] ph, logic [1:0] sel);
    logic [1:0]                        quad;
    logic [SINE_TABLE_ADDR_BITS-1:0]   idx;
    logic [TRI_W-1:0]                  lo;
    int                                hi;
    int                                v;
    quad = ph[PHASE_BITS-1 -: 2];
    v    = 0;
    case (sel)
      WAVE_SINE: begin
        idx = ph[PHASE_BITS-3 -: SINE_TABLE_ADDR_BITS];
        v   = quad[0] ? int'(sine_quarter[TBL_N - int'(idx)]) : int'(sine_quarter[idx]);
        if (quad[1]) v = -v;
      end
      WAVE_TRIANGLE: begin
        lo = ph[PHASE_BITS-3 -: TRI_W];
        hi = int'(lo) + ((|ph[PHASE_BITS-3-TRI_W:0]) ? 1 : 0);
        case (quad)
          2'd0:    v = int'(lo);
          2'd1:    v = AMP_INT - hi;
          2'd2:    v = -int'(lo);
          default: v = hi - AMP_INT;
        endcase
      end
      WAVE_SQUARE: v = ph[PHASE_BITS-1] ? -AMP_INT : AMP_INT;
      default:     v = 0;
    endcase
    return SAMPLE_W'(v);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic send_tick(input logic run);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(run);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (run) begin
      expected_samples.push_back(predict_sample(gen_phase, gen_wave));
      gen_phase = gen_phase + gen_step;
    end
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // waits until every predicted sample has been checked, then lets the block settle
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_generator(input logic [1:0] sel, input logic [STEP_W-1:0] step,
                                   input bit dirty_upper);
    logic [CFG_DATA_W-1:0] sel_word;
    drain_pipeline();
    sel_word = dirty_upper ? ((CFG_DATA_W'($urandom) & ~CFG_DATA_W'(3)) | CFG_DATA_W'(sel))
                           : CFG_DATA_W'(sel);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_WAVE_SELECT;
    cfg_data_i  <= sel_word;
    @(posedge clk_i);
    cfg_index_i <= REG_PHASE_STEP;
    cfg_data_i  <= step;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gen_wave = sel;
    gen_step = step;
  endtask

  task automatic test_reset_state();
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  task automatic test_sine_quadrants();
    // one tick with the negated phase lands the accumulator on zero
    program_generator(WAVE_SINE, STEP_W'(-gen_phase), 1'b0);
    send_tick(1'b1);
    program_generator(WAVE_SINE, STEP_W'(1) << (PHASE_BITS - 2), 1'b1);
    repeat (5) send_tick(1'b1);
  endtask

  task automatic test_triangle_slopes();
    program_generator(WAVE_TRIANGLE, 32'h3FFF_FFFF, 1'b0);
    repeat (5) send_tick(1'b1);
    program_generator(WAVE_TRIANGLE, 32'h0000_0001, 1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  task automatic test_square_and_unused();
    program_generator(WAVE_SQUARE, 32'h8000_0000, 1'b0);
    repeat (3) send_tick(1'b1);
    // unused selector gives zero but keeps the phase moving
    program_generator(2'd3, 32'hFFFF_FFFF, 1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_zero_step();
    program_generator(WAVE_TRIANGLE, 32'h0000_0000, 1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  task automatic test_random_ticks();
    logic [1:0]        sel;
    logic [STEP_W-1:0] step;
    int                kind;
    for (int ph = 0; ph < 20; ph++) begin
      sel  = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      kind = $urandom_range(0, 9);
      case (kind)
        0:       step = 32'h0000_0001;
        1:       step = 32'h8000_0000;
        2:       step = 32'hFFFF_FFFF;
        3:       step = 32'h0000_0000;
        4:       step = STEP_W'($urandom_range(1, 1 << 20));
        default: step = STEP_W'($urandom);
      endcase
      program_generator(sel, step, bit'($urandom_range(0, 1)));
      no_gaps = ($urandom_range(0, 2) == 0);
      repeat (75) send_tick($urandom_range(0, 99) < 80);
      no_gaps = 1'b0;
    end
  endtask

  // output side: long ready stretches or random stalls
  initial begin
    int r;
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      m_axis_tready <= 1'b1;
      if (r < 15) begin
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end else begin
        @(posedge clk_i);
        stall = pick_gap();
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    logic signed [SAMPLE_W-1:0] got;
    logic signed [SAMPLE_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[SAMPLE_W-1:0];
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected sample %0d", got));
      end else begin
        want = expected_samples.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("sample got %0d expected %0d", got, want));
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_waveform_generator failed");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    no_gaps        = 1'b0;
    gen_phase      = '0;
    gen_step       = STEP_RESET;
    gen_wave       = WAVE_SINE;
    sine_quarter[0] = '0;
    for (int k = 1; k < TBL_N; k++) sine_quarter[k] = sine_mag(k);
    sine_quarter[TBL_N] = MAG_W'(AMP_INT);

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= REG_WAVE_SELECT;
    cfg_data_i    <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_sine_quadrants();
    test_triangle_slopes();
    test_square_and_unused();
    test_zero_step();
    test_random_ticks();

    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("tb_waveform_generator passed");
    end else begin
      $display("tb_waveform_generator failed");
    end
    $finish;
  end

endmodule

@@ waveform_generator.f @@
hw/rtl/wg_pkg.sv
hw/rtl/wg_sine_rom.sv
hw/rtl/wg_shaper.sv
hw/rtl/waveform_generator.sv
bench/tb_waveform_generator.sv
